// ===== src/reaction_diffusion_1d_stencil_defines.svh =====
// ----------------------------------------------------------------------------
// Reaction-diffusion stencil assertion macros
// Concurrent assertion wrappers clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef REACTION_DIFFUSION_1D_STENCIL_DEFINES_SVH
`define REACTION_DIFFUSION_1D_STENCIL_DEFINES_SVH

`ifndef SYNTH
`define RD1D_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RD1D_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RD1D_ASSERT_NOW(lbl, ante, cons, msg)
`define RD1D_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/rd1d_pkg.sv =====
// ----------------------------------------------------------------------------
// Reaction-diffusion stencil package
// Transaction types, codes, states and saturation helpers.
// ----------------------------------------------------------------------------
package rd1d_pkg;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    localparam logic [2:0] CFG_SLOT_COUNT  = 3'd0;
    localparam logic [2:0] CFG_TIME_STEP   = 3'd1;
    localparam logic [2:0] CFG_DIFFUSION   = 3'd2;
    localparam logic [2:0] CFG_CONSUMPTION = 3'd3;
    localparam logic [2:0] CFG_SOURCE      = 3'd4;

    typedef struct packed {
        logic [1:0]         op;
        logic [7:0]         slot_index;
        logic signed [31:0] oxygen_in;
        logic [31:0]        cells_in;
    } req_t;

    typedef struct packed {
        logic signed [31:0] oxygen_out;
        logic               sweeps_clipped;
        logic               saturated;
    } rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RESP,
        ST_ADV_MUL,
        ST_ADV_Q,
        ST_DIV,
        ST_SW_START,
        ST_HD_MUL,
        ST_HD,
        ST_P0,
        ST_P1,
        ST_P2,
        ST_A,
        ST_B,
        ST_C,
        ST_D,
        ST_E,
        ST_F,
        ST_G,
        ST_END0,
        ST_END1
    } state_t;

    localparam int DIV_BITS = 26;

    function automatic logic sat_ovf(input logic signed [33:0] v);
        return (v > 34'sd2147483647) || (v < -34'sd2147483648);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -34'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== src/rd1d_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rd1d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/reaction_diffusion_1d_stencil.sv =====
// ----------------------------------------------------------------------------
// Reaction-diffusion 1D stencil
// Explicit Euler integration of oxygen over a grid held in on-chip RAM.
// ----------------------------------------------------------------------------
// Writes and reads take one transaction each; the response is registered and
// is presented once the output is free. With at least three slots in use, an
// advance first sets the substep h, found by division when 2*dt*D >= 1, and
// then runs its sweeps over the slots in use: every interior slot passes
// seven steps sharing the single 32x32 multiplier, with the oxygen RAM read
// one slot ahead and written back in place. The number of sweeps is
// ceil(dt/h), at least one, capped at MAX_SWEEPS. A new transaction is taken
// while a response waits at the output.
module reaction_diffusion_1d_stencil
    import rd1d_pkg::*;
#(
    parameter int SLOTS      = 256,
    parameter int MAX_SWEEPS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

`include "reaction_diffusion_1d_stencil_defines.svh"

    localparam int AW = $clog2(SLOTS);
    localparam int NW = $clog2(SLOTS + 1);
    localparam int CW = $clog2(MAX_SWEEPS + 1);
    localparam logic [CW-1:0] CAP = CW'(MAX_SWEEPS - 1);

    state_t state_reg, state_next;

    logic [8:0]  slot_count_reg;
    logic [31:0] time_step_reg, diffusion_reg, consumption_reg, source_reg;

    logic [1:0]    op_reg;
    logic          inrange_reg;
    logic [NW-1:0] n_reg;
    logic          clip_reg, sat_reg;
    logic          rsp_valid_reg;
    rsp_t          rsp_reg;

    logic [63:0] prod_reg;
    logic        neg_reg, sh16_reg;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic        mul_neg, mul_sh16;

    logic [DIV_BITS-1:0] div_num_reg, div_den_reg, div_quo_reg;
    logic [DIV_BITS:0]   div_rem_reg;
    logic [4:0]          div_cnt_reg;

    logic [31:0]   h_reg, cur_h_reg, hd_reg, elapsed_reg;
    logic          last_reg;
    logic [CW-1:0] count_reg;

    logic signed [31:0] xl_reg, xc_reg, xr_reg, kx_reg, xs_reg, r_reg, d_reg, hr_reg;
    logic [31:0]        c_reg;
    logic signed [31:0] first_reg, lastnew_reg;
    logic [AW-1:0]      i_reg;

    logic          o_we, o_re, c_we, c_re;
    logic [AW-1:0] o_waddr, o_raddr, c_raddr;
    logic [31:0]   o_wdata, o_rdata, c_rdata;

    logic          accept, req_inrange;
    logic [NW-1:0] n_eff;
    logic          rsp_free;

    logic [64:0]        rsum, mag;
    logic               post_ovf;
    logic signed [31:0] post_s;
    logic [31:0]        post_u;
    logic               post_u_ovf;

    logic signed [33:0] r_sum, d_sum, new_sum;
    logic signed [31:0] new_val;
    logic               full_step;
    logic [32:0]        step_sum;

    logic [24:0]         q_raw;
    logic [38:0]         q_rem;
    logic                q_up;
    logic [DIV_BITS-1:0] q_val, den_val, num_val;
    logic [DIV_BITS:0]   div_shift;

    assign accept      = req_valid && req_ready;
    assign req_inrange = 32'(req.slot_index) < SLOTS;
    assign n_eff       = (32'(slot_count_reg) > SLOTS) ? NW'(SLOTS) : NW'(slot_count_reg);
    assign rsp_free    = !rsp_valid_reg || rsp_ready;
    assign req_ready   = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign rsp_valid   = rsp_valid_reg;
    assign rsp         = rsp_reg;

    rd1d_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_oxy_ram (
        .clk   (clk),
        .we    (o_we),
        .waddr (o_waddr),
        .wdata (o_wdata),
        .re    (o_re),
        .raddr (o_raddr),
        .rdata (o_rdata)
    );

    rd1d_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_cell_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (o_waddr),
        .wdata (req.cells_in),
        .re    (c_re),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    always_comb
    begin
        rsum = {1'b0, prod_reg} + (sh16_reg ? (65'd1 << 15) : (65'd1 << 23));
        mag  = sh16_reg ? (rsum >> 16) : (rsum >> 24);
        if (neg_reg)
        begin
            post_ovf = mag > 65'h080000000;
            post_s   = post_ovf ? 32'sh80000000 : -$signed(mag[31:0]);
        end
        else
        begin
            post_ovf = mag > 65'h07FFFFFFF;
            post_s   = post_ovf ? 32'sh7FFFFFFF : $signed(mag[31:0]);
        end
        post_u_ovf = mag > 65'h0FFFFFFFF;
        post_u     = post_u_ovf ? 32'hFFFFFFFF : mag[31:0];
    end

    always_comb
    begin
        r_sum   = 34'(signed'({2'b00, source_reg})) - 34'(post_s) - 34'(xs_reg);
        d_sum   = 34'(xl_reg) + 34'(xr_reg) - (34'(xc_reg) <<< 1);
        new_sum = 34'(xc_reg) + 34'(hr_reg) + 34'(post_s);
        new_val = sat32(new_sum);
        step_sum  = {1'b0, elapsed_reg} + {1'b0, h_reg};
        full_step = step_sum < {1'b0, time_step_reg};
        q_raw   = prod_reg[63:39];
        q_rem   = prod_reg[38:0];
        q_up    = (q_rem > (39'd1 << 38)) || ((q_rem == (39'd1 << 38)) && q_raw[0]);
        q_val   = {1'b0, q_raw} + DIV_BITS'(q_up);
        den_val = q_val + DIV_BITS'(1);
        num_val = (DIV_BITS'(1) << 24) + (den_val >> 1);
        div_shift = {div_rem_reg[DIV_BITS-1:0], div_num_reg[DIV_BITS-1]};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.op == OP_ADVANCE && n_eff >= NW'(3))
                        state_next = ST_ADV_MUL;
                    else
                        state_next = ST_RESP;
                end
            end
            ST_RESP:     state_next = rsp_free ? ST_IDLE : ST_RESP;
            ST_ADV_MUL:  state_next = ST_ADV_Q;
            ST_ADV_Q:    state_next = (prod_reg[63:39] != '0) ? ST_DIV : ST_SW_START;
            ST_DIV:      state_next = (div_cnt_reg == 5'(DIV_BITS - 1)) ? ST_SW_START : ST_DIV;
            ST_SW_START:
            begin
                if (full_step && count_reg >= CAP)
                    state_next = ST_RESP;
                else
                    state_next = ST_HD_MUL;
            end
            ST_HD_MUL:   state_next = ST_HD;
            ST_HD:       state_next = ST_P0;
            ST_P0:       state_next = ST_P1;
            ST_P1:       state_next = ST_P2;
            ST_P2:       state_next = ST_A;
            ST_A:        state_next = ST_B;
            ST_B:        state_next = ST_C;
            ST_C:        state_next = ST_D;
            ST_D:        state_next = ST_E;
            ST_E:        state_next = ST_F;
            ST_F:        state_next = ST_G;
            ST_G:        state_next = (NW'(i_reg) == n_reg - NW'(2)) ? ST_END0 : ST_A;
            ST_END0:     state_next = ST_END1;
            ST_END1:     state_next = last_reg ? ST_RESP : ST_SW_START;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        o_we     = 1'b0;
        c_we     = 1'b0;
        o_re     = 1'b0;
        c_re     = 1'b0;
        o_waddr  = AW'(req.slot_index);
        o_wdata  = req.oxygen_in;
        o_raddr  = AW'(req.slot_index);
        c_raddr  = i_reg;
        mul_a    = '0;
        mul_b    = '0;
        mul_neg  = 1'b0;
        mul_sh16 = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && req_inrange)
                begin
                    o_we = (req.op == OP_WRITE);
                    c_we = (req.op == OP_WRITE);
                    o_re = (req.op == OP_READ);
                end
            end
            ST_ADV_MUL:
            begin
                mul_a = time_step_reg;
                mul_b = diffusion_reg;
            end
            ST_HD_MUL:
            begin
                mul_a    = cur_h_reg;
                mul_b    = diffusion_reg;
                mul_sh16 = 1'b1;
            end
            ST_P0:
            begin
                o_re    = 1'b1;
                o_raddr = '0;
            end
            ST_P1:
            begin
                o_re    = 1'b1;
                o_raddr = AW'(1);
            end
            ST_A:
            begin
                o_re    = 1'b1;
                c_re    = 1'b1;
                o_raddr = i_reg + AW'(1);
                mul_a   = xc_reg[31] ? 32'(-xc_reg) : xc_reg;
                mul_neg = xc_reg[31];
                mul_b   = consumption_reg;
            end
            ST_B:
            begin
                mul_a   = xc_reg[31] ? 32'(-xc_reg) : xc_reg;
                mul_neg = xc_reg[31];
                mul_b   = source_reg;
            end
            ST_C:
            begin
                mul_a    = kx_reg[31] ? 32'(-kx_reg) : kx_reg;
                mul_neg  = kx_reg[31];
                mul_b    = c_reg;
                mul_sh16 = 1'b1;
            end
            ST_E:
            begin
                mul_a   = r_reg[31] ? 32'(-r_reg) : r_reg;
                mul_neg = r_reg[31];
                mul_b   = cur_h_reg;
            end
            ST_F:
            begin
                mul_a   = d_reg[31] ? 32'(-d_reg) : d_reg;
                mul_neg = d_reg[31];
                mul_b   = hd_reg;
            end
            ST_G:
            begin
                o_we    = 1'b1;
                o_waddr = i_reg;
                o_wdata = new_val;
            end
            ST_END0:
            begin
                o_we    = 1'b1;
                o_waddr = '0;
                o_wdata = first_reg;
            end
            ST_END1:
            begin
                o_we    = 1'b1;
                o_waddr = AW'(n_reg - NW'(1));
                o_wdata = lastnew_reg;
            end
            default:
            begin
                o_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            slot_count_reg  <= 9'd256;
            time_step_reg   <= 32'h01000000;
            diffusion_reg   <= 32'h01000000;
            consumption_reg <= '0;
            source_reg      <= '0;
            rsp_valid_reg   <= 1'b0;
            clip_reg        <= 1'b0;
            sat_reg         <= 1'b0;
            op_reg          <= OP_NONE;
            inrange_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SLOT_COUNT:  slot_count_reg  <= cfg_data[8:0];
                    CFG_TIME_STEP:   time_step_reg   <= cfg_data;
                    CFG_DIFFUSION:   diffusion_reg   <= cfg_data;
                    CFG_CONSUMPTION: consumption_reg <= cfg_data;
                    CFG_SOURCE:      source_reg      <= cfg_data;
                    default:         slot_count_reg  <= slot_count_reg;
                endcase
            end
            if (accept)
            begin
                op_reg      <= req.op;
                inrange_reg <= req_inrange;
                clip_reg    <= 1'b0;
                sat_reg     <= 1'b0;
            end
            if (state_reg == ST_RESP && rsp_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && rsp_ready)
                rsp_valid_reg <= 1'b0;
            if (state_reg == ST_SW_START && full_step && count_reg >= CAP)
                clip_reg <= 1'b1;
            if ((state_reg == ST_HD && post_u_ovf)
                || ((state_reg == ST_B || state_reg == ST_C || state_reg == ST_F) && post_ovf)
                || (state_reg == ST_D && (post_ovf || sat_ovf(r_sum) || sat_ovf(d_sum)))
                || (state_reg == ST_G && (post_ovf || sat_ovf(new_sum))))
                sat_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        neg_reg  <= mul_neg;
        sh16_reg <= mul_sh16;
        if (state_reg == ST_RESP && rsp_free)
        begin
            rsp_reg.oxygen_out     <= (op_reg == OP_READ && inrange_reg) ? o_rdata : '0;
            rsp_reg.sweeps_clipped <= clip_reg;
            rsp_reg.saturated      <= sat_reg;
        end
        case (state_reg)
            ST_IDLE:
            begin
                n_reg       <= n_eff;
                elapsed_reg <= '0;
                count_reg   <= '0;
            end
            ST_ADV_Q:
            begin
                h_reg       <= time_step_reg;
                div_num_reg <= num_val;
                div_den_reg <= den_val;
                div_rem_reg <= '0;
                div_quo_reg <= '0;
                div_cnt_reg <= '0;
            end
            ST_DIV:
            begin
                div_num_reg <= div_num_reg << 1;
                div_cnt_reg <= div_cnt_reg + 5'd1;
                if (div_shift >= {1'b0, div_den_reg})
                begin
                    div_rem_reg <= div_shift - {1'b0, div_den_reg};
                    div_quo_reg <= {div_quo_reg[DIV_BITS-2:0], 1'b1};
                    if (div_cnt_reg == 5'(DIV_BITS - 1))
                        h_reg <= 32'({div_quo_reg[DIV_BITS-2:0], 1'b1});
                end
                else
                begin
                    div_rem_reg <= div_shift;
                    div_quo_reg <= {div_quo_reg[DIV_BITS-2:0], 1'b0};
                    if (div_cnt_reg == 5'(DIV_BITS - 1))
                        h_reg <= 32'({div_quo_reg[DIV_BITS-2:0], 1'b0});
                end
            end
            ST_SW_START:
            begin
                cur_h_reg <= full_step ? h_reg : time_step_reg - elapsed_reg;
                last_reg  <= !full_step;
            end
            ST_HD: hd_reg <= post_u;
            ST_P1: xl_reg <= o_rdata;
            ST_P2:
            begin
                xc_reg <= o_rdata;
                i_reg  <= AW'(1);
            end
            ST_B:
            begin
                xr_reg <= o_rdata;
                c_reg  <= c_rdata;
                kx_reg <= post_s;
            end
            ST_C: xs_reg <= post_s;
            ST_D:
            begin
                r_reg <= sat32(r_sum);
                d_reg <= sat32(d_sum);
            end
            ST_F: hr_reg <= post_s;
            ST_G:
            begin
                if (i_reg == AW'(1))
                    first_reg <= new_val;
                lastnew_reg <= new_val;
                xl_reg      <= xc_reg;
                xc_reg      <= xr_reg;
                i_reg       <= i_reg + AW'(1);
            end
            ST_END1:
            begin
                elapsed_reg <= elapsed_reg + cur_h_reg;
                count_reg   <= count_reg + CW'(1);
            end
            default:
            begin
                hd_reg <= hd_reg;
            end
        endcase
    end

    `RD1D_ASSERT_NXT(a_accept_leaves_idle, accept, state_reg != ST_IDLE, "idle after transaction")
    `RD1D_ASSERT_NOW(a_slot_in_range, state_reg == ST_G,
        (NW'(i_reg) >= NW'(1)) && (NW'(i_reg) + NW'(2) <= n_reg), "slot outside grid")
    `RD1D_ASSERT_NOW(a_clip_only_advance, rsp_valid && rsp.sweeps_clipped,
        rsp.oxygen_out == '0, "clip on non-advance response")
    `RD1D_ASSERT_NXT(a_resp_pending_holds, rsp_valid && !rsp_ready, rsp_valid, "response dropped")

endmodule

// ===== test/tb_reaction_diffusion_1d_stencil.sv =====
// ----------------------------------------------------------------------------
// Reaction-diffusion 1D stencil testbench
// Loads small grids and the full grid, reads them back and advances them under many register
// settings with random handshake gaps and stalls. A scoreboard predicts every
// response with its own fixed-point Euler integrator and checks each field.
// ----------------------------------------------------------------------------
module tb_reaction_diffusion_1d_stencil;
    import rd1d_pkg::*;

    localparam int GRID_SLOTS     = 256;
    localparam int SWEEP_CAP      = 4096;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int TARGET_ITEMS   = 580;

    class grid_scoreboard;
        logic [8:0]  slot_count;
        logic [31:0] time_step;
        logic [31:0] diffusion;
        logic [31:0] consumption;
        logic [31:0] source;
        int          oxygen [GRID_SLOTS];
        logic [31:0] cells [GRID_SLOTS];
        bit          sat_hit;
        rsp_t        expected_q [$];
        int          mismatches;
        int          advances;
        int          clipped;
        int          saturations;

        function new();
            slot_count  = 9'd256;
            time_step   = 32'h0100_0000;
            diffusion   = 32'h0100_0000;
            consumption = '0;
            source      = '0;
            foreach (oxygen[i])
            begin
                oxygen[i] = 0;
                cells[i]  = '0;
            end
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] data);
            case (idx)
                CFG_SLOT_COUNT:  slot_count  = data[8:0];
                CFG_TIME_STEP:   time_step   = data;
                CFG_DIFFUSION:   diffusion   = data;
                CFG_CONSUMPTION: consumption = data;
                CFG_SOURCE:      source      = data;
                default: ;
            endcase
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
            begin
                sat_hit = 1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648)
            begin
                sat_hit = 1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function longint scale_round(longint a, longint unsigned b, int sh);
            longint unsigned m;
            m = (a < 0) ? longint'(-a) : longint'(a);
            m = m * b;
            m = (m + (64'd1 << (sh - 1))) >> sh;
            return (a < 0) ? -$signed(m) : $signed(m);
        endfunction

        function void sweep(int n, logic [31:0] h);
            longint unsigned hd;
            longint x, kx, kxc, xs, r, d, hr, hdd;
            int next_level [GRID_SLOTS];
            hd = ({32'b0, h} * {32'b0, diffusion} + 64'd32768) >> 16;
            if (hd > 64'hFFFF_FFFF)
            begin
                sat_hit = 1;
                hd = 64'hFFFF_FFFF;
            end
            for (int i = 1; i + 1 < n; i++)
            begin
                x   = oxygen[i];
                kx  = clamp32(scale_round(x, {32'b0, consumption}, 24));
                kxc = clamp32(scale_round(kx, {32'b0, cells[i]}, 16));
                xs  = clamp32(scale_round(x, {32'b0, source}, 24));
                r   = clamp32(longint'({32'b0, source}) - kxc - xs);
                d   = clamp32(longint'(oxygen[i-1]) + longint'(oxygen[i+1]) - 2 * x);
                hr  = clamp32(scale_round(r, {32'b0, h}, 24));
                hdd = clamp32(scale_round(d, hd, 24));
                next_level[i] = int'(clamp32(x + hr + hdd));
            end
            oxygen[0]     = next_level[1];
            oxygen[n - 1] = next_level[n - 2];
            for (int i = 1; i + 1 < n; i++)
                oxygen[i] = next_level[i];
        endfunction

        function bit integrate();
            int n;
            int count;
            longint unsigned p, q, rem, elapsed;
            logic [31:0] h;
            n = (slot_count > GRID_SLOTS) ? GRID_SLOTS : int'(slot_count);
            count = 0;
            elapsed = 0;
            if (n < 3)
                return 0;
            p = {32'b0, time_step} * {32'b0, diffusion};
            if (p >= (64'd1 << 39))
            begin
                q = p >> 39;
                rem = p & ((64'd1 << 39) - 64'd1);
                if (rem > (64'd1 << 38) || (rem == (64'd1 << 38) && q[0]))
                    q++;
                h = 32'(((64'd1 << 24) + (q + 64'd1) / 64'd2) / (q + 64'd1));
            end
            else
                h = time_step;
            while (elapsed + {32'b0, h} < {32'b0, time_step})
            begin
                if (count >= SWEEP_CAP - 1)
                    return 1;
                sweep(n, h);
                elapsed += {32'b0, h};
                count++;
            end
            sweep(n, time_step - elapsed[31:0]);
            return 0;
        endfunction

        function void note_request(req_t t);
            rsp_t e;
            e = '0;
            case (op_t'(t.op))
                OP_WRITE:
                begin
                    oxygen[t.slot_index] = t.oxygen_in;
                    cells[t.slot_index]  = t.cells_in;
                end
                OP_ADVANCE:
                begin
                    sat_hit = 0;
                    e.sweeps_clipped = integrate();
                    e.saturated = sat_hit;
                    advances++;
                    clipped += e.sweeps_clipped;
                    saturations += e.saturated;
                end
                OP_READ: e.oxygen_out = oxygen[t.slot_index];
                default: ;
            endcase
            expected_q.push_back(e);
        endfunction

        function void check_response(rsp_t got);
            rsp_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: %h", got);
                return;
            end
            e = expected_q.pop_front();
            if (got.oxygen_out !== e.oxygen_out || got.sweeps_clipped !== e.sweeps_clipped
                || got.saturated !== e.saturated)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected oxygen %h clip %b sat %b, got %h %b %b",
                             e.oxygen_out, e.sweeps_clipped, e.saturated,
                             got.oxygen_out, got.sweeps_clipped, got.saturated);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_ready;
    rsp_t        rsp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    grid_scoreboard sb;
    bit written [GRID_SLOTS];
    int item_total;
    int phase_total;
    int burst_left;
    bit tx_gappy;
    int rx_mode;
    int hold_request;
    int hold_left;
    int rx_cycle;
    int idle_cycles;

    reaction_diffusion_1d_stencil dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(negedge clk)
    begin
        bit ready;
        rx_cycle++;
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (!rst_n)
            ready = 0;
        else if (hold_left > 0)
        begin
            ready = 0;
            hold_left--;
        end
        else if (rx_mode == 1)
            ready = ($urandom_range(0, 2) != 0);
        else if (rx_mode == 2)
            ready = ((rx_cycle % 7) < 4);
        else
            ready = 1;
        rsp_ready <= ready;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp);
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_item(req_t t);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = tx_gappy ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        req_valid <= 1'b1;
        req <= t;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(t);
        item_total++;
        if (op_t'(t.op) == OP_WRITE)
            written[t.slot_index] = 1;
    endtask

    task automatic send_op(op_t op, int idx, logic [31:0] ox, logic [31:0] ce);
        req_t t;
        t.op = op;
        t.slot_index = idx[7:0];
        t.oxygen_in = ox;
        t.cells_in = ce;
        send_item(t);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(int n, logic [31:0] dt, logic [31:0] d, logic [31:0] k,
                             logic [31:0] s);
        wait_drained();
        write_register(CFG_SLOT_COUNT, 32'(n));
        write_register(CFG_TIME_STEP, dt);
        write_register(CFG_DIFFUSION, d);
        write_register(CFG_CONSUMPTION, k);
        write_register(CFG_SOURCE, s);
        phase_total++;
    endtask

    function automatic logic [31:0] random_level();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return 32'($urandom_range(0, 134217728)) - 32'd67108864;
        endcase
    endfunction

    function automatic logic [31:0] random_cells();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 32'h0004_0000);
        endcase
    endfunction

    function automatic logic [31:0] random_rate();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 32'h0100_0000);
        endcase
    endfunction

    function automatic int pick_written(int n_eff);
        int idx;
        if (n_eff >= 3 && $urandom_range(0, 4) != 0)
            return $urandom_range(0, n_eff - 1);
        do
            idx = $urandom_range(0, GRID_SLOTS - 1);
        while (!written[idx]);
        return idx;
    endfunction

    task automatic run_phase(int n, logic [31:0] dt, logic [31:0] d, int items, int hold);
        int n_eff;
        int sel;
        configure(n, dt, d, random_rate(), random_rate());
        rx_mode = $urandom_range(0, 2);
        tx_gappy = ($urandom_range(0, 3) != 0);
        n_eff = (n > GRID_SLOTS) ? GRID_SLOTS : n;
        if (hold > 0)
            hold_request = hold;
        if (n_eff >= 3)
            for (int i = 0; i < n_eff; i++)
                send_op(OP_WRITE, i, random_level(), random_cells());
        repeat (items)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 4)
                send_op(OP_READ, pick_written(n_eff), $urandom, $urandom);
            else if (sel < 6)
                send_op(OP_WRITE, (n_eff >= 3 && sel == 4) ? $urandom_range(0, n_eff - 1)
                        : $urandom_range(0, GRID_SLOTS - 1), random_level(), random_cells());
            else if (sel < 9)
                send_op(OP_ADVANCE, $urandom_range(0, 255), $urandom, $urandom);
            else
                send_op(OP_NONE, $urandom_range(0, 255), $urandom, $urandom);
        end
    endtask

    task automatic directed_checks();
        configure(4, 32'h0100_0000, 32'h0000_8000, 32'h0010_0000, 32'h0008_0000);
        send_op(OP_WRITE, 0, 32'h7FFF_FFFF, 32'h0);
        send_op(OP_WRITE, 1, 32'h8000_0000, 32'hFFFF_FFFF);
        send_op(OP_WRITE, 2, 32'h0, 32'h0001_0000);
        send_op(OP_WRITE, 3, 32'h0100_0000, 32'h0002_0000);
        send_op(OP_WRITE, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 4; i++)
            send_op(OP_READ, i, 32'h0, 32'h0);
        send_op(OP_READ, 255, 32'h0, 32'h0);
        send_op(OP_ADVANCE, 0, 32'h0, 32'h0);
        send_op(OP_READ, 1, 32'h0, 32'h0);
        send_op(OP_READ, 2, 32'h0, 32'h0);
        send_op(OP_NONE, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        configure(4, 32'h0, 32'h0100_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_ADVANCE, 0, 32'h0, 32'h0);
        send_op(OP_READ, 0, 32'h0, 32'h0);
        send_op(OP_READ, 3, 32'h0, 32'h0);
        configure(2, 32'h0100_0000, 32'h0100_0000, 32'h0, 32'h0);
        send_op(OP_ADVANCE, 0, 32'h0, 32'h0);
        configure(0, 32'h0100_0000, 32'h0100_0000, 32'h0, 32'h0);
        send_op(OP_ADVANCE, 0, 32'h0, 32'h0);
        configure(3, 32'hFFFF_FFFF, 32'h0, 32'h0100_0000, 32'h0100_0000);
        send_op(OP_ADVANCE, 0, 32'h0, 32'h0);
        send_op(OP_READ, 1, 32'h0, 32'h0);
        configure(3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_op(OP_ADVANCE, 0, 32'h0, 32'h0);
        send_op(OP_READ, 0, 32'h0, 32'h0);
    endtask

    initial
    begin
        int n;
        logic [31:0] dt;
        logic [31:0] d;
        sb = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rx_mode = 0;
        tx_gappy = 0;
        burst_left = 0;
        hold_request = 0;
        hold_left = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        directed_checks();
        while (item_total < TARGET_ITEMS)
        begin
            if (phase_total == 8)
            begin
                // full grid with an oversized slot count, one sweep per advance
                run_phase(511, $urandom_range(0, 32'h0200_0000), 32'h0, 20, 300);
                continue;
            end
            case ($urandom_range(0, 19))
                0: n = $urandom_range(0, 2);
                1, 2, 3: n = $urandom_range(11, 40);
                default: n = $urandom_range(3, 10);
            endcase
            case ($urandom_range(0, 5))
                0: dt = '0;
                1: dt = 32'hFFFF_FFFF;
                default: dt = $urandom_range(0, 32'h0200_0000);
            endcase
            if (dt == 32'hFFFF_FFFF || $urandom_range(0, 5) == 0)
                d = '0;
            else if ($urandom_range(0, 1) == 0)
                d = $urandom_range(0, 32'h0001_0000);
            else
                d = $urandom_range(0, 32'h0004_0000);
            run_phase(n, dt, d, $urandom_range(20, 40), ($urandom_range(0, 5) == 0) ? 150 : 0);
        end
        wait_drained();
        repeat (50) @(posedge clk);

        $display("Covered %0d transactions over %0d register settings.", item_total,
                 phase_total);
        $display("Advances: %0d, clipped at sweep cap: %0d, saturating: %0d.",
                 sb.advances, sb.clipped, sb.saturations);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
        begin
            $display("Mismatches: %0d, responses missing: %0d", sb.mismatches, sb.pending());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/rd1d_pkg.sv
src/rd1d_ram.sv
src/reaction_diffusion_1d_stencil.sv
test/tb_reaction_diffusion_1d_stencil.sv
